// ----- hdl/wsd_pkg.sv -----
package wsd_pkg;

    // Channel limit and queue depth
    localparam int MaxChannels = 16;
    localparam int QDepth      = 4;
    localparam int QAw         = $clog2(QDepth);

    // Result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HEADER   = 3'd1;
    localparam logic [2:0] ERR_NO_FMT   = 3'd2;
    localparam logic [2:0] ERR_FORMAT   = 3'd3;
    localparam logic [2:0] ERR_NO_DATA  = 3'd4;
    localparam logic [2:0] ERR_NO_FRAME = 3'd5;

    // Chunk tags, first byte in the low bits
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Format codes
    localparam logic [15:0] FMT_PCM        = 16'h0001;
    localparam logic [15:0] FMT_FLOAT      = 16'h0003;
    localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

    localparam logic [31:0] F32_INF = 32'h7F80_0000;
    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_CHDR,
        PH_FMT,
        PH_DATA,
        PH_SKIP,
        PH_WAIT
    } phase_t;

    typedef enum logic [2:0] {
        FC_I16,
        FC_I24,
        FC_I32,
        FC_F32,
        FC_F64
    } fcls_t;

    // Fields that ride along with each result
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  ch;
        logic        fe;
        logic [2:0]  err;
        logic [31:0] rate;
        logic [31:0] frames;
        logic        last;
    } meta_t;

    // One queue entry from parser to converter
    typedef struct packed {
        meta_t       meta;
        fcls_t       fcls;
        logic [63:0] raw;
    } entry_t;

endpackage

// ----- hdl/wsd_div.sv -----
module wsd_div
    import wsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [4:0]  divisor,
    output logic        busy,
    output logic [15:0] quot
);

    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  rem_reg, rem_next;
    logic [15:0] qd_reg, qd_next;
    logic [4:0]  dsr_reg, dsr_next;
    logic [4:0]  trial;

    // One quotient bit per cycle, restoring
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, qd_reg[15]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 4'd15;
            rem_next  = 4'd0;
            qd_next   = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= dsr_reg) begin
                rem_next = 4'(trial - dsr_reg);
                qd_next  = {qd_reg[14:0], 1'b1};
            end else begin
                rem_next = trial[3:0];
                qd_next  = {qd_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign quot = qd_reg;

endmodule

// ----- hdl/wsd_front.sv -----
module wsd_front
    import wsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_wdata
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  bcnt_reg, bcnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] clen_reg, clen_next;
    logic [31:0] crem_reg, crem_next;
    logic [15:0] fmtc_reg, fmtc_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] balign_reg, balign_next;
    logic [15:0] bits_reg, bits_next;
    logic        sfmt_reg, sfmt_next;
    logic        sdata_reg, sdata_next;
    logic [63:0] buf_reg, buf_next;
    logic [15:0] fo_reg, fo_next;
    logic [15:0] w_reg, w_next;
    logic [4:0]  c_reg, c_next;
    logic [31:0] frames_reg, frames_next;
    logic        pad_reg, pad_next;
    logic [4:0]  foff_reg, foff_next;
    logic        xv_reg, xv_next;
    entry_t      x_reg, x_next;

    logic        accept;
    logic        div_start, div_busy;
    logic [15:0] stride;
    logic        fmt_ok;
    logic [8:0]  need_align;
    logic [15:0] bps;
    logic        smp_v, err_v, eof_v;
    logic [2:0]  err_code;
    entry_t      smp_it, err_it, eof_it, it0;
    logic        it0_v;
    fcls_t       fcls;

    wsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (balign_reg),
        .divisor  (chan_reg[4:0]),
        .busy     (div_busy),
        .quot     (stride)
    );

    assign s_tready = !q_full && !xv_reg && !div_busy;
    assign accept   = s_tvalid && s_tready;
    assign bps      = {3'd0, bits_reg[15:3]};

    // Format check at the start of the data chunk
    always_comb begin
        need_align = 9'(chan_reg[4:0] * bits_reg[6:3]);
        fmt_ok = (chan_reg != 16'd0) && (chan_reg <= 16'(MaxChannels))
            && (rate_reg != 32'd0) && (balign_reg != 16'd0);
        if (fmtc_reg == FMT_PCM) begin
            fmt_ok = fmt_ok && (bits_reg == 16'd16 || bits_reg == 16'd24
                || bits_reg == 16'd32);
        end else if (fmtc_reg == FMT_FLOAT) begin
            fmt_ok = fmt_ok && (bits_reg == 16'd32 || bits_reg == 16'd64);
        end else begin
            fmt_ok = 1'b0;
        end
        fmt_ok = fmt_ok && (balign_reg >= {7'd0, need_align});
    end

    // Sample class from format and width
    always_comb begin
        if (fmtc_reg == FMT_FLOAT) begin
            fcls = (bits_reg == 16'd64) ? FC_F64 : FC_F32;
        end else if (bits_reg == 16'd16) begin
            fcls = FC_I16;
        end else if (bits_reg == 16'd24) begin
            fcls = FC_I24;
        end else begin
            fcls = FC_I32;
        end
    end

    // Parse one byte
    always_comb begin
        phase_next  = phase_reg;
        bcnt_next   = bcnt_reg;
        tag_next    = tag_reg;
        clen_next   = clen_reg;
        crem_next   = crem_reg;
        fmtc_next   = fmtc_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        balign_next = balign_reg;
        bits_next   = bits_reg;
        sfmt_next   = sfmt_reg;
        sdata_next  = sdata_reg;
        buf_next    = buf_reg;
        fo_next     = fo_reg;
        w_next      = w_reg;
        c_next      = c_reg;
        frames_next = frames_reg;
        pad_next    = pad_reg;
        foff_next   = foff_reg;
        div_start   = 1'b0;
        smp_v       = 1'b0;
        err_v       = 1'b0;
        err_code    = ERR_NONE;
        eof_v       = 1'b0;
        smp_it      = '0;
        err_it      = '0;
        eof_it      = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_HDR: begin
                    tag_next = {s_tdata, tag_reg[31:8]};
                    if ((bcnt_reg == 4'd3 && tag_next != TAG_RIFF)
                        || (bcnt_reg == 4'd11 && tag_next != TAG_WAVE)) begin
                        err_v      = 1'b1;
                        err_code   = ERR_HEADER;
                        phase_next = PH_WAIT;
                    end else if (bcnt_reg == 4'd11) begin
                        phase_next = PH_CHDR;
                        bcnt_next  = 4'd0;
                    end else begin
                        bcnt_next = bcnt_reg + 4'd1;
                    end
                end
                PH_CHDR: begin
                    if (pad_reg) begin
                        pad_next = 1'b0;
                    end else begin
                        if (bcnt_reg < 4'd4) begin
                            tag_next = {s_tdata, tag_reg[31:8]};
                        end else begin
                            clen_next = {s_tdata, clen_reg[31:8]};
                        end
                        bcnt_next = bcnt_reg + 4'd1;
                        if (bcnt_reg == 4'd7) begin
                            // Header complete: pick the chunk's handling
                            bcnt_next = 4'd0;
                            crem_next = clen_next;
                            if (tag_next == TAG_FMT && !sfmt_reg
                                && clen_next >= 32'd16) begin
                                sfmt_next  = 1'b1;
                                phase_next = PH_FMT;
                                foff_next  = 5'd0;
                            end else if (tag_next == TAG_DATA && !sdata_reg) begin
                                sdata_next = 1'b1;
                                if (!sfmt_reg) begin
                                    err_v    = 1'b1;
                                    err_code = ERR_NO_FMT;
                                end else if (!fmt_ok) begin
                                    err_v    = 1'b1;
                                    err_code = ERR_FORMAT;
                                end else begin
                                    fo_next     = 16'd0;
                                    w_next      = 16'd0;
                                    c_next      = 5'd0;
                                    frames_next = 32'd0;
                                    phase_next  = PH_DATA;
                                    div_start   = 1'b1;
                                end
                            end else begin
                                phase_next = PH_SKIP;
                            end
                            if (err_v) begin
                                phase_next = PH_WAIT;
                            end else if (clen_next == 32'd0) begin
                                pad_next   = 1'b0;
                                phase_next = PH_CHDR;
                            end
                        end
                    end
                end
                PH_FMT, PH_DATA, PH_SKIP: begin
                    if (phase_reg == PH_FMT) begin
                        // Capture the fmt fields as their last byte lands
                        tag_next  = {s_tdata, tag_reg[31:8]};
                        foff_next = (foff_reg == 5'd31) ? foff_reg : foff_reg + 5'd1;
                        case (foff_reg)
                            5'd1:  fmtc_next   = tag_next[31:16];
                            5'd3:  chan_next   = tag_next[31:16];
                            5'd7:  rate_next   = tag_next;
                            5'd13: balign_next = tag_next[31:16];
                            5'd15: bits_next   = tag_next[31:16];
                            5'd25: begin
                                if (fmtc_reg == FMT_EXTENSIBLE && clen_reg >= 32'd40) begin
                                    fmtc_next = tag_next[31:16];
                                end
                            end
                            default: ;
                        endcase
                    end else if (phase_reg == PH_DATA) begin
                        // Gather sample bytes; walk channel stride and frame
                        if ({11'd0, c_reg} < chan_reg && w_reg < bps) begin
                            for (int i = 0; i < 8; i++) begin
                                if (w_reg[2:0] == 3'(i)) begin
                                    buf_next[i*8 +: 8] = s_tdata;
                                end else if (w_reg == 16'd0) begin
                                    buf_next[i*8 +: 8] = 8'd0;
                                end
                            end
                            if (w_reg == bps - 16'd1) begin
                                smp_v              = 1'b1;
                                smp_it.meta.kind   = KIND_SAMPLE;
                                smp_it.meta.ch     = c_reg[3:0];
                                smp_it.meta.fe     = ({11'd0, c_reg} == chan_reg - 16'd1);
                                smp_it.fcls        = fcls;
                                smp_it.raw         = buf_next;
                            end
                        end
                        if (w_reg + 16'd1 == stride) begin
                            w_next = 16'd0;
                            c_next = (c_reg == 5'd16) ? c_reg : c_reg + 5'd1;
                        end else begin
                            w_next = w_reg + 16'd1;
                        end
                        if ({1'b0, fo_reg} + 17'd1 >= {1'b0, balign_reg}) begin
                            fo_next     = 16'd0;
                            w_next      = 16'd0;
                            c_next      = 5'd0;
                            frames_next = frames_reg + 32'd1;
                        end else begin
                            fo_next = fo_reg + 16'd1;
                        end
                    end
                    crem_next = crem_reg - 32'd1;
                    if (crem_next == 32'd0) begin
                        pad_next   = clen_reg[0];
                        phase_next = PH_CHDR;
                        bcnt_next  = 4'd0;
                    end
                end
                PH_WAIT: ;
                default: ;
            endcase

            err_it.meta.kind = KIND_ERROR;
            err_it.meta.err  = err_code;

            // Close the file on its last byte
            if (s_tlast) begin
                if (phase_next == PH_HDR) begin
                    eof_v            = 1'b1;
                    eof_it.meta.kind = KIND_ERROR;
                    eof_it.meta.err  = ERR_HEADER;
                end else if (phase_next != PH_WAIT) begin
                    eof_v = 1'b1;
                    if (!sdata_next) begin
                        eof_it.meta.kind = KIND_ERROR;
                        eof_it.meta.err  = ERR_NO_DATA;
                    end else if (frames_next == 32'd0) begin
                        eof_it.meta.kind = KIND_ERROR;
                        eof_it.meta.err  = ERR_NO_FRAME;
                    end else begin
                        eof_it.meta.kind   = KIND_DONE;
                        eof_it.meta.rate   = rate_next;
                        eof_it.meta.frames = frames_next;
                    end
                end
                phase_next  = PH_HDR;
                bcnt_next   = 4'd0;
                tag_next    = 32'd0;
                clen_next   = 32'd0;
                crem_next   = 32'd0;
                fmtc_next   = 16'd0;
                chan_next   = 16'd0;
                rate_next   = 32'd0;
                balign_next = 16'd0;
                bits_next   = 16'd0;
                sfmt_next   = 1'b0;
                sdata_next  = 1'b0;
                buf_next    = 64'd0;
                fo_next     = 16'd0;
                w_next      = 16'd0;
                c_next      = 5'd0;
                frames_next = 32'd0;
                pad_next    = 1'b0;
                foff_next   = 5'd0;
            end
        end
    end

    // Order the results of this byte; hold a second one until the queue has room
    always_comb begin
        xv_next = xv_reg;
        x_next  = x_reg;
        it0_v   = smp_v || err_v || eof_v;
        if (smp_v) begin
            it0 = smp_it;
        end else if (err_v) begin
            it0 = err_it;
        end else begin
            it0 = eof_it;
        end
        it0.meta.last = !(smp_v && eof_v);
        if (smp_v && eof_v) begin
            xv_next          = 1'b1;
            x_next           = eof_it;
            x_next.meta.last = 1'b1;
        end else if (xv_reg && !q_full) begin
            xv_next = 1'b0;
        end
        q_push  = (accept && it0_v) || (xv_reg && !q_full);
        q_wdata = xv_reg ? x_reg : it0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR;
            bcnt_reg   <= 4'd0;
            tag_reg    <= 32'd0;
            clen_reg   <= 32'd0;
            crem_reg   <= 32'd0;
            fmtc_reg   <= 16'd0;
            chan_reg   <= 16'd0;
            rate_reg   <= 32'd0;
            balign_reg <= 16'd0;
            bits_reg   <= 16'd0;
            sfmt_reg   <= 1'b0;
            sdata_reg  <= 1'b0;
            fo_reg     <= 16'd0;
            w_reg      <= 16'd0;
            c_reg      <= 5'd0;
            frames_reg <= 32'd0;
            pad_reg    <= 1'b0;
            foff_reg   <= 5'd0;
            xv_reg     <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            bcnt_reg   <= bcnt_next;
            tag_reg    <= tag_next;
            clen_reg   <= clen_next;
            crem_reg   <= crem_next;
            fmtc_reg   <= fmtc_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            balign_reg <= balign_next;
            bits_reg   <= bits_next;
            sfmt_reg   <= sfmt_next;
            sdata_reg  <= sdata_next;
            fo_reg     <= fo_next;
            w_reg      <= w_next;
            c_reg      <= c_next;
            frames_reg <= frames_next;
            pad_reg    <= pad_next;
            foff_reg   <= foff_next;
            xv_reg     <= xv_next;
        end
        buf_reg <= buf_next;
        x_reg   <= x_next;
    end

endmodule

// ----- hdl/wsd_fifo.sv -----
module wsd_fifo
    import wsd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t wdata,
    input  logic   pop,
    output entry_t rdata,
    output logic   full,
    output logic   empty
);

    entry_t         mem_reg [QDepth];
    logic [QAw-1:0] wp_reg, rp_reg;
    logic [QAw:0]   cnt_reg;

    assign full  = (cnt_reg == (QAw+1)'(QDepth));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/wsd_back.sv -----
module wsd_back
    import wsd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_empty,
    input  entry_t       q_rdata,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    // Stage A: unpack
    logic        va_reg;
    meta_t       ma_reg;
    logic        spa_reg, sga_reg, inta_reg;
    logic [31:0] swa_reg;
    logic [4:0]  eoa_reg;
    logic [63:0] wa_reg;
    logic [5:0]  sha_reg;
    logic [7:0]  eba_reg;
    // Stage B: normalize
    logic        vb_reg;
    meta_t       mb_reg;
    logic        spb_reg, sgb_reg;
    logic [31:0] swb_reg;
    logic [63:0] wb_reg;
    logic [5:0]  shb_reg;
    logic [7:0]  ebb_reg;
    // Stage C: align
    logic        vc_reg;
    meta_t       mc_reg;
    logic        spc_reg, sgc_reg, gc_reg, stc_reg;
    logic [31:0] swc_reg;
    logic [23:0] qc_reg;
    logic [7:0]  ebc_reg;
    // Stage D: output
    logic        vd_reg;
    meta_t       md_reg;
    logic [31:0] wd_reg;

    logic        adv_a, adv_b, adv_c, adv_d;
    logic        sp_a, sg_a, int_a;
    logic [31:0] sw_a, sv_a, mag_a;
    logic [4:0]  eo_a;
    logic [63:0] w_a;
    logic [5:0]  sh_a;
    logic [7:0]  eb_a;
    logic [10:0] ex;
    logic [5:0]  lz;
    logic [5:0]  sh_b;
    logic [7:0]  eb_b;
    logic [127:0] full_c;
    logic [24:0] qr;
    logic [31:0] sum_d, word_d;

    // Stall chain from the output back to the queue
    assign adv_d = !vd_reg || m_tready;
    assign adv_c = !vc_reg || adv_d;
    assign adv_b = !vb_reg || adv_c;
    assign adv_a = !va_reg || adv_b;
    assign q_pop = !q_empty && adv_a;

    // Stage A: sign-extend integers, split float64
    always_comb begin
        sp_a  = 1'b0;
        sg_a  = 1'b0;
        int_a = 1'b0;
        sw_a  = 32'd0;
        sv_a  = 32'd0;
        eo_a  = 5'd0;
        w_a   = 64'd0;
        sh_a  = 6'd0;
        eb_a  = 8'd0;
        mag_a = 32'd0;
        ex    = q_rdata.raw[62:52];
        if (q_rdata.meta.kind != KIND_SAMPLE) begin
            sp_a = 1'b1;
        end else begin
            unique case (q_rdata.fcls)
                FC_I16, FC_I24, FC_I32: begin
                    int_a = 1'b1;
                    if (q_rdata.fcls == FC_I16) begin
                        sv_a = {{16{q_rdata.raw[15]}}, q_rdata.raw[15:0]};
                        eo_a = 5'd15;
                    end else if (q_rdata.fcls == FC_I24) begin
                        sv_a = {{8{q_rdata.raw[23]}}, q_rdata.raw[23:0]};
                        eo_a = 5'd23;
                    end else begin
                        sv_a = q_rdata.raw[31:0];
                        eo_a = 5'd31;
                    end
                    sg_a  = sv_a[31];
                    mag_a = sv_a[31] ? (32'd0 - sv_a) : sv_a;
                    w_a   = {mag_a, 32'd0};
                    sp_a  = (sv_a == 32'd0);
                end
                FC_F32: begin
                    sp_a = 1'b1;
                    sw_a = q_rdata.raw[31:0];
                end
                FC_F64: begin
                    sg_a = q_rdata.raw[63];
                    w_a  = {11'd0, 1'b1, q_rdata.raw[51:0]};
                    if (ex == 11'h7FF) begin
                        sp_a = 1'b1;
                        if (q_rdata.raw[51:0] == 52'd0) begin
                            sw_a = {sg_a, 31'd0} | F32_INF;
                        end else begin
                            sw_a = {sg_a, 31'd0} | F32_QNAN | {9'd0, q_rdata.raw[51:29]};
                        end
                    end else if (ex == 11'd0 || ex <= 11'd872) begin
                        sp_a = 1'b1;
                        sw_a = {sg_a, 31'd0};
                    end else if (ex >= 11'd1151) begin
                        sp_a = 1'b1;
                        sw_a = {sg_a, 31'd0} | F32_INF;
                    end else if (ex >= 11'd897) begin
                        sh_a = 6'd29;
                        eb_a = 8'(ex - 11'd897);
                    end else begin
                        sh_a = 6'(11'd926 - ex);
                        eb_a = 8'd0;
                    end
                end
                default: sp_a = 1'b1;
            endcase
        end
    end

    // Stage B: leading-zero count for integers
    always_comb begin
        lz = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (wa_reg[32+i]) begin
                lz = 6'(31 - i);
            end
        end
        if (inta_reg) begin
            sh_b = 6'd40 - lz;
            eb_b = 8'(9'd157 - {3'd0, lz} - {4'd0, eoa_reg});
        end else begin
            sh_b = sha_reg;
            eb_b = eba_reg;
        end
    end

    // Stage C: align significand, keep guard and sticky
    assign full_c = {wb_reg, 64'd0} >> shb_reg;

    // Stage D: round to nearest even and pack
    always_comb begin
        qr    = {1'b0, qc_reg} + {24'd0, (gc_reg && (stc_reg || qc_reg[0]))};
        sum_d = {1'b0, ebc_reg, 23'd0} + {7'd0, qr};
        if (sum_d >= F32_INF) begin
            sum_d = F32_INF;
        end
        word_d = spc_reg ? swc_reg : {sgc_reg, sum_d[30:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (adv_a) va_reg <= q_pop;
            if (adv_b) vb_reg <= va_reg;
            if (adv_c) vc_reg <= vb_reg;
            if (adv_d) vd_reg <= vc_reg;
        end
        if (adv_a) begin
            ma_reg   <= q_rdata.meta;
            spa_reg  <= sp_a;
            sga_reg  <= sg_a;
            inta_reg <= int_a;
            swa_reg  <= sw_a;
            eoa_reg  <= eo_a;
            wa_reg   <= w_a;
            sha_reg  <= sh_a;
            eba_reg  <= eb_a;
        end
        if (adv_b) begin
            mb_reg  <= ma_reg;
            spb_reg <= spa_reg;
            sgb_reg <= sga_reg;
            swb_reg <= swa_reg;
            wb_reg  <= wa_reg;
            shb_reg <= sh_b;
            ebb_reg <= eb_b;
        end
        if (adv_c) begin
            mc_reg  <= mb_reg;
            spc_reg <= spb_reg;
            sgc_reg <= sgb_reg;
            swc_reg <= swb_reg;
            qc_reg  <= full_c[87:64];
            gc_reg  <= full_c[63];
            stc_reg <= |full_c[62:0];
            ebc_reg <= ebb_reg;
        end
        if (adv_d) begin
            md_reg <= mc_reg;
            wd_reg <= word_d;
        end
    end

    assign m_tvalid = vd_reg;
    assign m_tuser  = md_reg.kind;
    assign m_tlast  = md_reg.last;
    assign m_tdata  = {md_reg.frames, md_reg.rate, md_reg.err, md_reg.fe,
                       md_reg.ch, wd_reg};

endmodule

// ----- hdl/wav_stream_sample_decoder_unit.sv -----
// A sample passes the queue and the 4 converter stages: unpack, normalize, align, output.
// Throughput: one file byte per cycle while the queue has room; a byte that yields two items
// holds s_tready low until both are queued, as does the divider after a valid data header.
// Converter stages stall independently of the parser through a 4-entry queue.
// Reset: aresetn low at a rising edge clears the parser to expect the RIFF header
// and empties the queue and the output stage.
module wav_stream_sample_decoder_unit
    import wsd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // file_byte
    input  logic         s_tlast,   // end_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_word[31:0], channel_index[35:32], frame_end[36], error_code[39:37],
    // rate_out[71:40], frames_out[103:72]
    output logic [103:0] m_tdata,
    output logic [1:0]   m_tuser,   // item_kind
    output logic         m_tlast    // run_last
);

    logic   q_push, q_pop, q_full, q_empty;
    entry_t q_wdata, q_rdata;

    wsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    wsd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    wsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/wsd_checker.sv -----
module wsd_checker
    import wsd_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    // Hold a stalled item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled item changed");

    // Done and error items always close the run of their byte
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_ERROR) |-> m_tlast)
        else $error("done or error item not marked last");

    // Samples carry no error code and no totals
    a_smp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SAMPLE |-> m_tdata[103:37] == '0)
        else $error("sample item carries totals or error");

    // Error items carry a nonzero code and no sample
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[39:37] != ERR_NONE
            && m_tdata[36:0] == '0)
        else $error("error item malformed");

endmodule

bind wav_stream_sample_decoder_unit wsd_checker u_chk (.*);
